@@ hdl/mesh_vertex_normal_average_defines.svh @@
// ----------------------------------------------------------------------------
// mesh vertex normal average assertion macros
// concurrent assertion wrappers, empty when SYNTH is set
// ----------------------------------------------------------------------------
`ifndef MESH_VERTEX_NORMAL_AVERAGE_DEFINES_SVH
`define MESH_VERTEX_NORMAL_AVERAGE_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication
`define MVNA_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mvna assertion failed");
// next-cycle implication
`define MVNA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mvna assertion failed");
`else
`define MVNA_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define MVNA_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ hdl/mvna_pkg.sv @@
// ----------------------------------------------------------------------------
// mvna_pkg
// shared types and constants of the vertex normal averaging block
// ----------------------------------------------------------------------------
package mvna_pkg;

   localparam int MAX_VERTICES_DEF = 1024;
   localparam int IDX_W            = 10;
   localparam int COORD_W          = 16;
   localparam int SUM_W            = 24;
   localparam int CNT_W            = 8;
   localparam int STEP_W           = 5;

   // last step of each multi-cycle phase; STEP_VERTEX selects the vertex address
   localparam int CORNER_LAST = 2;
   localparam int STEP_VERTEX = 3;
   localparam int MUL_LAST    = 6;
   localparam int SQ_LAST     = 3;
   localparam int SQRT_LAST   = 31;
   localparam int DIV_LAST    = 14;

   typedef enum logic [1:0] {
      OP_STORE    = 2'd0,
      OP_TRIANGLE = 2'd1,
      OP_READOUT  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK           = 2'd0,
      STATUS_NO_TRIANGLES = 2'd1,
      STATUS_ZERO_SUM     = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0]              operation;
      logic [IDX_W-1:0]        vertex_index;
      logic signed [COORD_W-1:0] coord_x;
      logic signed [COORD_W-1:0] coord_y;
      logic signed [COORD_W-1:0] coord_z;
      logic [IDX_W-1:0]        corner_a;
      logic [IDX_W-1:0]        corner_b;
      logic [IDX_W-1:0]        corner_c;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] normal_x;
      logic signed [COORD_W-1:0] normal_y;
      logic signed [COORD_W-1:0] normal_z;
      logic [CNT_W-1:0]        adjacent_triangles;
      logic [1:0]              status;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PT_READ,
      ST_DIFF,
      ST_MUL,
      ST_SUM_READ,
      ST_SUM_LOAD,
      ST_CHECK,
      ST_MAG,
      ST_SQ,
      ST_SQRT_INIT,
      ST_SQRT,
      ST_DIV_INIT,
      ST_DIV,
      ST_RESULT,
      ST_RMW_READ,
      ST_RMW_WRITE,
      ST_OUT
   } state_type;

   typedef enum logic [4:0] {
      CMD_NOP,
      CMD_CLEAR,
      CMD_STORE,
      CMD_LATCH,
      CMD_PT_READ,
      CMD_DIFF,
      CMD_MUL,
      CMD_SUM_READ,
      CMD_SUM_LOAD,
      CMD_MAG,
      CMD_SQ,
      CMD_SQRT_INIT,
      CMD_SQRT,
      CMD_DIV_INIT,
      CMD_DIV,
      CMD_RESULT,
      CMD_RMW_WRITE,
      CMD_OUT
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [STEP_W-1:0] step;
      status_type        rsp_status;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic v_zero;
      logic count_zero;
      logic corners_ok;
      logic out_free;
   } sts_type;

endpackage

@@ hdl/mesh_vertex_normal_average.sv @@
// ----------------------------------------------------------------------------
// mesh_vertex_normal_average
// Averaged unit vertex normals of a triangle mesh, no area weighting. A store
// transaction writes one vertex (Q1.14 coordinates) while idle. A triangle
// transaction forms (B-A)x(C-A), scales it to unit length and adds it to the
// saturating sums and counts of its three corners; degenerate triangles and
// triangles with an out-of-range corner change nothing. A readout transaction
// returns the unit-length summed normal, the triangle count and a status code.
// Normalising runs the 32-step square root and the 15-step divider lanes, one
// item at a time. After reset the sum and count memory is swept to zero while
// no transaction is accepted.
// ----------------------------------------------------------------------------
module mesh_vertex_normal_average import mvna_pkg::*; #(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   // request channel
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   // response channel
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // command and status between sequencer and datapath
   cmd_type cmd;
   sts_type sts;

   // sequencer: one transaction in flight, stalls request side when busy
   mvna_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_data.operation),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: memories, arithmetic and the registered response
   mvna_datapath #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

@@ hdl/mvna_datapath.sv @@
// ----------------------------------------------------------------------------
// mvna_datapath
// vertex and sum memories, cross product, root and divider lanes, output register
// ----------------------------------------------------------------------------
module mvna_datapath import mvna_pkg::*; #(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  req_type req_data,
   input  cmd_type cmd,
   output sts_type sts,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int AW = $clog2(MAX_VERTICES);

   logic [3*COORD_W-1:0]       pt_mem [MAX_VERTICES];
   logic [3*SUM_W+CNT_W-1:0]   sum_mem [MAX_VERTICES];

   req_type                    rq_ff;
   logic [AW-1:0]              clr_ff;
   logic [3*COORD_W-1:0]       pt_rd_ff;
   logic [3*SUM_W+CNT_W-1:0]   sum_rd_ff;
   logic signed [COORD_W-1:0]  pa_ff [3];
   logic signed [COORD_W-1:0]  pb_ff [3];
   logic signed [16:0]         ab_ff [3];
   logic signed [16:0]         ac_ff [3];
   logic signed [33:0]         prod_ff;
   logic signed [34:0]         v_ff [3];
   logic [29:0]                mag_ff [3];
   logic [59:0]                sq_ff;
   logic [61:0]                len_ff;
   logic [61:0]                rad_ff;
   logic [62:0]                root_ff;
   logic [62:0]                bit_ff;
   logic [30:0]                rem_ff [3];
   logic [14:0]                lo_ff [3];
   logic [14:0]                q_ff [3];
   logic signed [COORD_W-1:0]  n_ff [3];
   logic [CNT_W-1:0]           cnt_ff;
   logic                       rsp_valid_ff;
   rsp_type                    rsp_ff;

   logic signed [COORD_W-1:0]  pt_c [3];
   logic signed [COORD_W-1:0]  pt_sel [3];
   logic signed [SUM_W-1:0]    sum_c [3];
   logic [CNT_W-1:0]           sum_cnt;
   logic [33:0]                abs_v [3];
   logic [33:0]                mx;
   logic [2:0]                 shamt;
   logic signed [16:0]         mul_a;
   logic signed [16:0]         mul_b;
   logic [2:0]                 acc_step;
   logic [62:0]                trial;
   logic [44:0]                num [3];
   logic [31:0]                dsh [3];
   logic [30:0]                r_div;
   logic [AW-1:0]              sum_addr;
   logic                       sum_we;
   logic                       sum_re;
   logic [3*SUM_W+CNT_W-1:0]   sum_wd;
   logic                       out_load;

   function automatic logic [AW-1:0] to_addr(logic [IDX_W-1:0] idx);
      logic [16:0] ext;
      ext = {7'd0, idx};
      return ext[AW-1:0];
   endfunction

   function automatic logic in_range(logic [IDX_W-1:0] idx);
      return {7'd0, idx} < 17'(MAX_VERTICES);
   endfunction

   function automatic logic [IDX_W-1:0] corner_of(req_type r, logic [1:0] k);
      logic [IDX_W-1:0] res;
      case (k)
         2'd0: begin
            res = r.corner_a;
         end
         2'd1: begin
            res = r.corner_b;
         end
         default: begin
            res = r.corner_c;
         end
      endcase
      return res;
   endfunction

   function automatic logic signed [SUM_W-1:0] sat_add(logic signed [SUM_W-1:0] a,
                                                       logic signed [COORD_W-1:0] b);
      logic signed [SUM_W:0] t;
      t = (SUM_W+1)'(a) + (SUM_W+1)'(b);
      if (t > (SUM_W+1)'(signed'({2'b00, {(SUM_W-1){1'b1}}}))) begin
         return {1'b0, {(SUM_W-1){1'b1}}};
      end else if (t < (SUM_W+1)'(signed'({2'b11, {(SUM_W-1){1'b0}}}))) begin
         return {1'b1, {(SUM_W-1){1'b0}}};
      end
      return t[SUM_W-1:0];
   endfunction

   // field views
   always_comb begin
      pt_c[0] = signed'(pt_rd_ff[47:32]);
      pt_c[1] = signed'(pt_rd_ff[31:16]);
      pt_c[2] = signed'(pt_rd_ff[15:0]);
      sum_c[0] = signed'(sum_rd_ff[79:56]);
      sum_c[1] = signed'(sum_rd_ff[55:32]);
      sum_c[2] = signed'(sum_rd_ff[31:8]);
      sum_cnt  = sum_rd_ff[7:0];
      for (int k = 0; k < 3; k++) begin
         pt_sel[k] = pt_c[k];
      end
   end

   // magnitude and pre-shift
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         abs_v[k] = v_ff[k][34] ? 34'(-v_ff[k]) : 34'(v_ff[k]);
      end
      mx = abs_v[0];
      if (abs_v[1] > mx) begin
         mx = abs_v[1];
      end
      if (abs_v[2] > mx) begin
         mx = abs_v[2];
      end
      if (mx[33]) begin
         shamt = 3'd4;
      end else if (mx[32]) begin
         shamt = 3'd3;
      end else if (mx[31]) begin
         shamt = 3'd2;
      end else if (mx[30]) begin
         shamt = 3'd1;
      end else begin
         shamt = 3'd0;
      end
   end

   // cross product operand schedule
   always_comb begin
      case (cmd.step[2:0])
         3'd0: begin
            mul_a = ab_ff[1];
            mul_b = ac_ff[2];
         end
         3'd1: begin
            mul_a = ab_ff[2];
            mul_b = ac_ff[1];
         end
         3'd2: begin
            mul_a = ab_ff[2];
            mul_b = ac_ff[0];
         end
         3'd3: begin
            mul_a = ab_ff[0];
            mul_b = ac_ff[2];
         end
         3'd4: begin
            mul_a = ab_ff[0];
            mul_b = ac_ff[1];
         end
         3'd5: begin
            mul_a = ab_ff[1];
            mul_b = ac_ff[0];
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      acc_step = cmd.step[2:0] - 3'd1;
   end

   // root step and divider lanes
   always_comb begin
      trial = root_ff + bit_ff;
      r_div = root_ff[30:0];
      for (int k = 0; k < 3; k++) begin
         num[k] = {1'b0, mag_ff[k], 14'd0} + 45'(root_ff[30:1]);
         dsh[k] = {rem_ff[k], lo_ff[k][14]};
      end
   end

   // sum memory port
   always_comb begin
      sum_we = 1'b0;
      sum_re = 1'b0;
      sum_wd = '0;
      if (cmd.step == STEP_W'(STEP_VERTEX)) begin
         sum_addr = to_addr(rq_ff.vertex_index);
      end else begin
         sum_addr = to_addr(corner_of(rq_ff, cmd.step[1:0]));
      end
      case (cmd.kind)
         CMD_CLEAR: begin
            sum_addr = clr_ff;
            sum_we   = 1'b1;
         end
         CMD_SUM_READ: begin
            sum_re = 1'b1;
         end
         CMD_RMW_WRITE: begin
            sum_we = 1'b1;
            sum_wd = {sat_add(sum_c[0], n_ff[0]), sat_add(sum_c[1], n_ff[1]),
                      sat_add(sum_c[2], n_ff[2]),
                      (sum_cnt == {CNT_W{1'b1}}) ? sum_cnt : sum_cnt + CNT_W'(1)};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (sum_we) begin
         sum_mem[sum_addr] <= sum_wd;
      end
      if (sum_re) begin
         sum_rd_ff <= sum_mem[sum_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.kind == CMD_STORE && in_range(req_data.vertex_index)) begin
         pt_mem[to_addr(req_data.vertex_index)] <=
            {req_data.coord_x, req_data.coord_y, req_data.coord_z};
      end
      if (cmd.kind == CMD_PT_READ) begin
         pt_rd_ff <= pt_mem[to_addr(corner_of(rq_ff, cmd.step[1:0]))];
      end
   end

   // control registers
   assign out_load = (cmd.kind == CMD_OUT);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.kind == CMD_CLEAR) begin
            clr_ff <= clr_ff + AW'(1);
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // arithmetic registers
   always_ff @(posedge clock) begin
      case (cmd.kind)
         CMD_LATCH: begin
            rq_ff <= req_data;
         end
         CMD_PT_READ: begin
            if (cmd.step == STEP_W'(1)) begin
               pa_ff <= pt_sel;
            end else if (cmd.step == STEP_W'(2)) begin
               pb_ff <= pt_sel;
            end
         end
         CMD_DIFF: begin
            for (int k = 0; k < 3; k++) begin
               ab_ff[k] <= 17'(pb_ff[k]) - 17'(pa_ff[k]);
               ac_ff[k] <= 17'(pt_sel[k]) - 17'(pa_ff[k]);
            end
         end
         CMD_MUL: begin
            prod_ff <= mul_a * mul_b;
            if (cmd.step != '0) begin
               if (acc_step[0]) begin
                  v_ff[acc_step[2:1]] <= v_ff[acc_step[2:1]] - 35'(prod_ff);
               end else begin
                  v_ff[acc_step[2:1]] <= 35'(prod_ff);
               end
            end
         end
         CMD_SUM_LOAD: begin
            for (int k = 0; k < 3; k++) begin
               v_ff[k] <= 35'(sum_c[k]);
            end
            cnt_ff <= in_range(rq_ff.vertex_index) ? sum_cnt : '0;
         end
         CMD_MAG: begin
            for (int k = 0; k < 3; k++) begin
               mag_ff[k] <= 30'(abs_v[k] >> shamt);
            end
         end
         CMD_SQ: begin
            if (cmd.step < STEP_W'(3)) begin
               sq_ff <= mag_ff[cmd.step[1:0]] * mag_ff[cmd.step[1:0]];
            end
            if (cmd.step == STEP_W'(1)) begin
               len_ff <= 62'(sq_ff);
            end else if (cmd.step != '0) begin
               len_ff <= len_ff + 62'(sq_ff);
            end
         end
         CMD_SQRT_INIT: begin
            rad_ff  <= len_ff;
            root_ff <= '0;
            bit_ff  <= 63'(1) << 62;
         end
         CMD_SQRT: begin
            if ({1'b0, rad_ff} >= trial) begin
               rad_ff  <= rad_ff - trial[61:0];
               root_ff <= (root_ff >> 1) + bit_ff;
            end else begin
               root_ff <= root_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         CMD_DIV_INIT: begin
            for (int k = 0; k < 3; k++) begin
               rem_ff[k] <= {1'b0, num[k][44:15]};
               lo_ff[k]  <= num[k][14:0];
               q_ff[k]   <= '0;
            end
         end
         CMD_DIV: begin
            for (int k = 0; k < 3; k++) begin
               if (dsh[k] >= {1'b0, r_div}) begin
                  rem_ff[k] <= 31'(dsh[k] - {1'b0, r_div});
                  q_ff[k]   <= {q_ff[k][13:0], 1'b1};
               end else begin
                  rem_ff[k] <= dsh[k][30:0];
                  q_ff[k]   <= {q_ff[k][13:0], 1'b0};
               end
               lo_ff[k] <= {lo_ff[k][13:0], 1'b0};
            end
         end
         CMD_RESULT: begin
            for (int k = 0; k < 3; k++) begin
               if (r_div == '0) begin
                  n_ff[k] <= '0;
               end else if (q_ff[k] > 15'd16384) begin
                  n_ff[k] <= v_ff[k][34] ? -16'sd16384 : 16'sd16384;
               end else begin
                  n_ff[k] <= v_ff[k][34] ? -signed'({1'b0, q_ff[k]})
                                         : signed'({1'b0, q_ff[k]});
               end
            end
         end
         CMD_OUT: begin
            rsp_ff.normal_x           <= (cmd.rsp_status == STATUS_OK) ? n_ff[0] : '0;
            rsp_ff.normal_y           <= (cmd.rsp_status == STATUS_OK) ? n_ff[1] : '0;
            rsp_ff.normal_z           <= (cmd.rsp_status == STATUS_OK) ? n_ff[2] : '0;
            rsp_ff.adjacent_triangles <= cnt_ff;
            rsp_ff.status             <= cmd.rsp_status;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      sts.clear_last = (clr_ff == AW'(MAX_VERTICES - 1));
      sts.v_zero     = (v_ff[0] == '0) && (v_ff[1] == '0) && (v_ff[2] == '0);
      sts.count_zero = (cnt_ff == '0);
      sts.corners_ok = in_range(rq_ff.corner_a) && in_range(rq_ff.corner_b)
                       && in_range(rq_ff.corner_c);
      sts.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ hdl/mvna_ctrl.sv @@
// ----------------------------------------------------------------------------
// mvna_ctrl
// sequencer for store, triangle and readout transactions
// ----------------------------------------------------------------------------
`include "mesh_vertex_normal_average_defines.svh"

module mvna_ctrl import mvna_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_op,
   output logic       req_stall,
   input  sts_type    sts,
   output cmd_type    cmd
);

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              is_tri_ff, is_tri_in;
   status_type        code_ff, code_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         step_ff   <= '0;
         is_tri_ff <= 1'b0;
         code_ff   <= STATUS_OK;
      end else begin
         state_ff  <= state_in;
         step_ff   <= step_in;
         is_tri_ff <= is_tri_in;
         code_ff   <= code_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      step_in        = step_ff;
      is_tri_in      = is_tri_ff;
      code_in        = code_ff;
      req_stall      = 1'b1;
      cmd.kind       = CMD_NOP;
      cmd.step       = step_ff;
      cmd.rsp_status = code_ff;
      case (state_ff)
         ST_CLEAR: begin
            cmd.kind = CMD_CLEAR;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            step_in   = '0;
            if (req_valid) begin
               case (req_op)
                  OP_STORE: begin
                     cmd.kind = CMD_STORE;
                  end
                  OP_TRIANGLE: begin
                     cmd.kind  = CMD_LATCH;
                     is_tri_in = 1'b1;
                     state_in  = ST_PT_READ;
                  end
                  OP_READOUT: begin
                     cmd.kind  = CMD_LATCH;
                     is_tri_in = 1'b0;
                     state_in  = ST_SUM_READ;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_PT_READ: begin
            if (step_ff == '0 && !sts.corners_ok) begin
               state_in = ST_IDLE;
            end else begin
               cmd.kind = CMD_PT_READ;
               if (step_ff == STEP_W'(CORNER_LAST)) begin
                  state_in = ST_DIFF;
                  step_in  = '0;
               end else begin
                  step_in = step_ff + STEP_W'(1);
               end
            end
         end
         ST_DIFF: begin
            cmd.kind = CMD_DIFF;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.kind = CMD_MUL;
            if (step_ff == STEP_W'(MUL_LAST)) begin
               state_in = ST_MAG;
               step_in  = '0;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         ST_SUM_READ: begin
            cmd.kind = CMD_SUM_READ;
            cmd.step = STEP_W'(STEP_VERTEX);
            state_in = ST_SUM_LOAD;
         end
         ST_SUM_LOAD: begin
            cmd.kind = CMD_SUM_LOAD;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (sts.count_zero) begin
               code_in  = STATUS_NO_TRIANGLES;
               state_in = ST_OUT;
            end else if (sts.v_zero) begin
               code_in  = STATUS_ZERO_SUM;
               state_in = ST_OUT;
            end else begin
               state_in = ST_MAG;
            end
         end
         ST_MAG: begin
            if (is_tri_ff && sts.v_zero) begin
               state_in = ST_IDLE;
            end else begin
               cmd.kind = CMD_MAG;
               state_in = ST_SQ;
               step_in  = '0;
            end
         end
         ST_SQ: begin
            cmd.kind = CMD_SQ;
            if (step_ff == STEP_W'(SQ_LAST)) begin
               state_in = ST_SQRT_INIT;
               step_in  = '0;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         ST_SQRT_INIT: begin
            cmd.kind = CMD_SQRT_INIT;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.kind = CMD_SQRT;
            if (step_ff == STEP_W'(SQRT_LAST)) begin
               state_in = ST_DIV_INIT;
               step_in  = '0;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         ST_DIV_INIT: begin
            cmd.kind = CMD_DIV_INIT;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.kind = CMD_DIV;
            if (step_ff == STEP_W'(DIV_LAST)) begin
               state_in = ST_RESULT;
               step_in  = '0;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         ST_RESULT: begin
            cmd.kind = CMD_RESULT;
            if (is_tri_ff) begin
               state_in = ST_RMW_READ;
            end else begin
               code_in  = STATUS_OK;
               state_in = ST_OUT;
            end
         end
         ST_RMW_READ: begin
            cmd.kind = CMD_SUM_READ;
            state_in = ST_RMW_WRITE;
         end
         ST_RMW_WRITE: begin
            cmd.kind = CMD_RMW_WRITE;
            if (step_ff == STEP_W'(CORNER_LAST)) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_RMW_READ;
               step_in  = step_ff + STEP_W'(1);
            end
         end
         ST_OUT: begin
            if (sts.out_free) begin
               cmd.kind = CMD_OUT;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `MVNA_ASSERT_IMPL(a_out_only_when_free, clock, reset, (cmd.kind == CMD_OUT), sts.out_free)
   `MVNA_ASSERT_NEXT(a_clear_ends, clock, reset, (state_ff == ST_CLEAR && sts.clear_last), (state_ff == ST_IDLE))
   `MVNA_ASSERT_NEXT(a_degenerate_skipped, clock, reset, (state_ff == ST_MAG && is_tri_ff && sts.v_zero), (state_ff == ST_IDLE))
   `MVNA_ASSERT_IMPL(a_rmw_corner_bound, clock, reset, (state_ff == ST_RMW_WRITE), (step_ff <= STEP_W'(CORNER_LAST)))

endmodule
